### rtl/core/gse_pkg.sv
`default_nettype none
package gse_pkg;

  typedef enum logic [1:0] {
    CMD_LOAD_POS    = 2'd0,
    CMD_LOAD_VEL    = 2'd1,
    CMD_LOAD_THRUST = 2'd2,
    CMD_BODY        = 2'd3
  } cmd_t;

  localparam logic [31:0] STEP_RESET = 32'd65536;
  localparam logic [63:0] MAXPOS = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MINNEG = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic [1:0]  command;
    logic [63:0] coord_x;
    logic [63:0] coord_y;
    logic [63:0] coord_z;
    logic [63:0] magnitude;
    logic        is_barycenter;
    logic        last_body;
  } in_word_t;

  typedef struct packed {
    logic [63:0] pos_x;
    logic [63:0] pos_y;
    logic [63:0] pos_z;
    logic [63:0] vel_x;
    logic [63:0] vel_y;
    logic [63:0] vel_z;
  } out_word_t;

  // shift-add multiplier request/response
  typedef struct packed {
    logic         start;
    logic [63:0]  a;
    logic [63:0]  b;
  } mul_req_t;

  typedef struct packed {
    logic         done;
    logic [127:0] p;
  } mul_rsp_t;

  // restoring divider: 128-bit dividend by 64-bit divisor
  typedef struct packed {
    logic         start;
    logic [127:0] x;
    logic [63:0]  d;
  } div_req_t;

  typedef struct packed {
    logic         done;
    logic [127:0] q;
  } div_rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DIFF,
    ST_NORM,
    ST_SQ,
    ST_SQ_W,
    ST_SQRT,
    ST_GM,
    ST_GM_W,
    ST_DIV1,
    ST_DIV1_W,
    ST_DIV2,
    ST_DIV2_W,
    ST_ACC,
    ST_TH,
    ST_TH_W,
    ST_AV,
    ST_AV_W,
    ST_PV,
    ST_PV_W,
    ST_OUT
  } state_t;

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    if ((a[63] == b[63]) && (s[63] != a[63])) begin
      return a[63] ? MINNEG : MAXPOS;
    end
    return s;
  endfunction

  function automatic logic [63:0] from_mag(input logic neg, input logic [127:0] m);
    if (!neg) begin
      return ((|m[127:64]) || (m[63:0] > MAXPOS)) ? MAXPOS : m[63:0];
    end
    return ((|m[127:64]) || (m[63:0] > MINNEG)) ? MINNEG : (64'd0 - m[63:0]);
  endfunction

endpackage
`default_nettype wire

### rtl/core/gse_if.sv
`default_nettype none
interface gse_in_if import gse_pkg::*; ();
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface gse_out_if import gse_pkg::*; ();
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface gse_cfg_if ();
  logic        valid;
  logic        ready;
  logic [31:0] data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/core/gse_mul.sv
`default_nettype none
module gse_mul import gse_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  mul_req_t  req,
  output mul_rsp_t  rsp
);
  // two bits of the multiplier per cycle
  logic [127:0] acc_r, acc_nxt;
  logic [127:0] mcand_r, mcand_nxt;
  logic [63:0]  mplier_r, mplier_nxt;
  logic [5:0]   cnt_r, cnt_nxt;
  logic         busy_r, busy_nxt;
  logic         done_r, done_nxt;
  logic [127:0] pp;

  always_comb begin
    pp = (mplier_r[0] ? mcand_r : 128'd0) + (mplier_r[1] ? {mcand_r[126:0], 1'b0} : 128'd0);
    acc_nxt    = acc_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    cnt_nxt    = cnt_r;
    busy_nxt   = busy_r;
    done_nxt   = 1'b0;
    if (req.start) begin
      acc_nxt    = '0;
      mcand_nxt  = {64'd0, req.a};
      mplier_nxt = req.b;
      cnt_nxt    = '0;
      busy_nxt   = 1'b1;
    end else if (busy_r) begin
      acc_nxt    = acc_r + pp;
      mcand_nxt  = {mcand_r[125:0], 2'b00};
      mplier_nxt = {2'b00, mplier_r[63:2]};
      cnt_nxt    = cnt_r + 6'd1;
      if (cnt_r == 6'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r    <= acc_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.p    = acc_r;
endmodule
`default_nettype wire

### rtl/core/gse_div.sv
`default_nettype none
module gse_div import gse_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  div_req_t  req,
  output div_rsp_t  rsp
);
  // restoring division, one quotient bit per cycle
  logic [127:0] q_r, q_nxt;
  logic [63:0]  rem_r, rem_nxt;
  logic [63:0]  d_r, d_nxt;
  logic [7:0]   cnt_r, cnt_nxt;
  logic         busy_r, busy_nxt;
  logic         done_r, done_nxt;
  logic [64:0]  trial;

  always_comb begin
    trial    = {rem_r, q_r[127]};
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      q_nxt    = req.x;
      rem_nxt  = '0;
      d_nxt    = req.d;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // dividend bits shift out of q while quotient bits shift in
      if (trial >= {1'b0, d_r}) begin
        rem_nxt = 64'(trial - {1'b0, d_r});
        q_nxt   = {q_r[126:0], 1'b1};
      end else begin
        rem_nxt = trial[63:0];
        q_nxt   = {q_r[126:0], 1'b0};
      end
      cnt_nxt = cnt_r + 8'd1;
      if (cnt_r == 8'd127) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.q    = q_r;
endmodule
`default_nettype wire

### rtl/core/gravity_sum_euler_step_core.sv
`default_nettype none
// Gravity sum and semi-implicit Euler step for one ship, fixed point. Load words
// (command 0..2) are taken straight from idle, as is a barycenter word that is not last.
// An attractor word runs its arithmetic bit-serially through one shared 2-bit/cycle
// multiplier and one restoring divider (one quotient bit per cycle): three squares,
// a 32-step square root, then per axis one product and two divisions. The last body
// adds the integration: nine products. A result word is held in an output register
// until taken; the next word is accepted after.
module gravity_sum_euler_step_core import gse_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  gse_in_if.sink        in_ch,
  gse_out_if.source     out_ch,
  gse_cfg_if.sink       cfg_ch
);

  state_t state_r, state_nxt;

  // architectural state
  logic [31:0] step_r;
  logic [63:0] pos_r [3];
  logic [63:0] vel_r [3];
  logic [63:0] dir_r [3];
  logic [63:0] accel_r;
  logic [63:0] grav_r [3];

  // per-body working registers
  logic [63:0] body_r [3];
  logic [63:0] gm_r;
  logic        last_r;
  logic [63:0] mag_r [3];
  logic        neg_r [3];
  logic [30:0] u_r [3];
  logic [6:0]  len_r;
  logic [63:0] s_r;
  logic [1:0]  ax_r;
  logic        ovf_r;
  logic [127:0] tmp_r;
  logic [63:0] term_r;

  // square root registers: one result bit per cycle
  logic [63:0] sq_x_r, sq_res_r, sq_bit_r;

  logic [63:0] out_r [6];
  logic        out_valid_r;

  mul_req_t mreq;
  mul_rsp_t mrsp;
  div_req_t dreq;
  div_rsp_t drsp;

  gse_mul u_mul (.clk, .rst_n, .req(mreq), .rsp(mrsp));
  gse_div u_div (.clk, .rst_n, .req(dreq), .rsp(drsp));

  assign cfg_ch.ready = (state_r == ST_IDLE) && !out_valid_r;
  assign in_ch.ready  = (state_r == ST_IDLE) && !out_valid_r;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = '{pos_x: out_r[0], pos_y: out_r[1], pos_z: out_r[2],
                          vel_x: out_r[3], vel_y: out_r[4], vel_z: out_r[5]};

  wire logic in_fire = in_ch.valid && in_ch.ready;

  // bit length of the largest magnitude, via a 64-bit priority scan
  logic [63:0] maxmag;
  logic [6:0]  blen;
  always_comb begin
    maxmag = mag_r[0];
    if (mag_r[1] > maxmag) maxmag = mag_r[1];
    if (mag_r[2] > maxmag) maxmag = mag_r[2];
    blen = '0;
    for (int i = 0; i < 64; i++) begin
      if (maxmag[i]) blen = 7'(i + 1);
    end
  end

  // signed operand magnitude for the scaled products, held through the wait
  logic [63:0] sop;
  logic        sneg;
  logic [63:0] smag;
  logic [8:0]  e_s;
  always_comb begin
    case (state_r)
      ST_TH, ST_TH_W: sop = dir_r[ax_r];
      ST_AV, ST_AV_W: sop = term_r;
      default:        sop = vel_r[ax_r];
    endcase
    sneg = sop[63];
    smag = sneg ? (64'd0 - sop) : sop;
    e_s  = 9'(9'sd118 - 9'(2 * len_r));
  end

  logic [63:0] sq_trial;
  assign sq_trial = sq_res_r + sq_bit_r;

  always_comb begin
    state_nxt = state_r;
    mreq = '0;
    dreq = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && in_ch.data.command == CMD_BODY) begin
          if (!in_ch.data.is_barycenter) state_nxt = ST_DIFF;
          else if (in_ch.data.last_body) state_nxt = ST_TH;
        end
      end
      ST_DIFF: state_nxt = ST_NORM;
      ST_NORM: state_nxt = (blen == 7'd0) ? (last_r ? ST_TH : ST_IDLE) : ST_SQ;
      ST_SQ: begin
        mreq = '{start: 1'b1, a: {33'd0, u_r[ax_r]}, b: {33'd0, u_r[ax_r]}};
        state_nxt = ST_SQ_W;
      end
      ST_SQ_W: if (mrsp.done) state_nxt = (ax_r == 2'd2) ? ST_SQRT : ST_SQ;
      ST_SQRT: if (sq_bit_r == 64'd0) state_nxt = ST_GM;
      ST_GM: begin
        mreq = '{start: 1'b1, a: gm_r, b: {33'd0, u_r[ax_r]}};
        state_nxt = ST_GM_W;
      end
      ST_GM_W: if (mrsp.done) state_nxt = ST_DIV1;
      ST_DIV1: begin
        dreq = '{start: 1'b1, x: tmp_r, d: sq_res_r};
        state_nxt = ST_DIV1_W;
      end
      ST_DIV1_W: if (drsp.done) state_nxt = ST_DIV2;
      ST_DIV2: begin
        dreq = '{start: 1'b1, x: tmp_r, d: s_r};
        state_nxt = ST_DIV2_W;
      end
      ST_DIV2_W: if (drsp.done) state_nxt = ST_ACC;
      ST_ACC: begin
        if (ax_r != 2'd2) state_nxt = ST_GM;
        else state_nxt = last_r ? ST_TH : ST_IDLE;
      end
      ST_TH: begin
        mreq = '{start: 1'b1, a: smag, b: accel_r};
        state_nxt = ST_TH_W;
      end
      ST_TH_W: if (mrsp.done) state_nxt = ST_AV;
      ST_AV: begin
        mreq = '{start: 1'b1, a: smag, b: {32'd0, step_r}};
        state_nxt = ST_AV_W;
      end
      ST_AV_W: if (mrsp.done) state_nxt = (ax_r == 2'd2) ? ST_PV : ST_TH;
      ST_PV: begin
        mreq = '{start: 1'b1, a: smag, b: {32'd0, step_r}};
        state_nxt = ST_PV_W;
      end
      ST_PV_W: if (mrsp.done) state_nxt = (ax_r == 2'd2) ? ST_OUT : ST_PV;
      ST_OUT: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      step_r      <= STEP_RESET;
      accel_r     <= '0;
      for (int i = 0; i < 3; i++) begin
        pos_r[i]  <= '0;
        vel_r[i]  <= '0;
        dir_r[i]  <= '0;
        grav_r[i] <= '0;
      end
      ax_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_ch.valid && out_ch.ready) out_valid_r <= 1'b0;
      if (cfg_ch.valid && cfg_ch.ready) step_r <= cfg_ch.data;
      case (state_r)
        ST_IDLE: begin
          ax_r <= '0;
          if (in_fire) begin
            last_r <= in_ch.data.last_body;
            gm_r   <= in_ch.data.magnitude;
            body_r[0] <= in_ch.data.coord_x;
            body_r[1] <= in_ch.data.coord_y;
            body_r[2] <= in_ch.data.coord_z;
            case (in_ch.data.command)
              CMD_LOAD_POS: begin
                pos_r[0] <= in_ch.data.coord_x;
                pos_r[1] <= in_ch.data.coord_y;
                pos_r[2] <= in_ch.data.coord_z;
              end
              CMD_LOAD_VEL: begin
                vel_r[0] <= in_ch.data.coord_x;
                vel_r[1] <= in_ch.data.coord_y;
                vel_r[2] <= in_ch.data.coord_z;
              end
              CMD_LOAD_THRUST: begin
                dir_r[0] <= in_ch.data.coord_x;
                dir_r[1] <= in_ch.data.coord_y;
                dir_r[2] <= in_ch.data.coord_z;
                accel_r  <= in_ch.data.magnitude;
              end
              default: ;
            endcase
          end
        end
        ST_DIFF: begin
          for (int i = 0; i < 3; i++) begin
            if ({~body_r[i][63], body_r[i][62:0]} >= {~pos_r[i][63], pos_r[i][62:0]}) begin
              mag_r[i] <= body_r[i] - pos_r[i];
              neg_r[i] <= 1'b0;
            end else begin
              mag_r[i] <= pos_r[i] - body_r[i];
              neg_r[i] <= 1'b1;
            end
          end
        end
        ST_NORM: begin
          len_r <= blen;
          s_r   <= '0;
          for (int i = 0; i < 3; i++) begin
            if (blen > 7'd31) u_r[i] <= 31'(mag_r[i] >> (blen - 7'd31));
            else u_r[i] <= 31'(mag_r[i] << (7'd31 - blen));
          end
        end
        ST_SQ_W: begin
          if (mrsp.done) begin
            s_r <= s_r + mrsp.p[63:0];
            if (ax_r == 2'd2) begin
              ax_r     <= '0;
              sq_x_r   <= s_r + mrsp.p[63:0];
              sq_res_r <= '0;
              sq_bit_r <= 64'h4000_0000_0000_0000;
            end else begin
              ax_r <= ax_r + 2'd1;
            end
          end
        end
        ST_SQRT: begin
          // bit-pair restoring square root
          if (sq_bit_r != 64'd0) begin
            if (sq_x_r >= sq_trial) begin
              sq_x_r   <= sq_x_r - sq_trial;
              sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
            end else begin
              sq_res_r <= sq_res_r >> 1;
            end
            sq_bit_r <= sq_bit_r >> 2;
          end
        end
        ST_GM_W: if (mrsp.done) tmp_r <= mrsp.p;
        ST_DIV1_W: begin
          if (drsp.done) begin
            // apply 2^e; a scaled value past 128 bits saturates the pull
            if (!e_s[8]) begin
              if ((len_r <= 7'd59) && (|(drsp.q >> (8'd128 - 8'(e_s)))) &&
                  (e_s != 9'd0)) begin
                ovf_r <= 1'b1;
                tmp_r <= drsp.q;
              end else begin
                ovf_r <= 1'b0;
                tmp_r <= drsp.q << e_s[7:0];
              end
            end else begin
              ovf_r <= 1'b0;
              tmp_r <= drsp.q >> 8'(9'd0 - e_s);
            end
          end
        end
        ST_DIV2_W: if (drsp.done) tmp_r <= ovf_r ? {64'd1, 64'd0} : drsp.q;
        ST_ACC: begin
          grav_r[ax_r] <= sat_add(grav_r[ax_r], from_mag(neg_r[ax_r], tmp_r));
          ax_r <= (ax_r == 2'd2) ? 2'd0 : ax_r + 2'd1;
        end
        ST_TH_W: begin
          if (mrsp.done) term_r <= sat_add(from_mag(sneg, mrsp.p >> 56), grav_r[ax_r]);
        end
        ST_AV_W: begin
          if (mrsp.done) begin
            vel_r[ax_r] <= sat_add(vel_r[ax_r], from_mag(sneg, mrsp.p >> 16));
            ax_r <= (ax_r == 2'd2) ? 2'd0 : ax_r + 2'd1;
          end
        end
        ST_PV_W: begin
          if (mrsp.done) begin
            pos_r[ax_r] <= sat_add(pos_r[ax_r], from_mag(sneg, mrsp.p >> 16));
            ax_r <= (ax_r == 2'd2) ? 2'd0 : ax_r + 2'd1;
          end
        end
        ST_OUT: begin
          out_valid_r <= 1'b1;
          for (int i = 0; i < 3; i++) begin
            out_r[i]     <= pos_r[i];
            out_r[3 + i] <= vel_r[i];
            grav_r[i]    <= '0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

### dv/gravity_sum_euler_step_core_tb.sv
`default_nettype none
module gravity_sum_euler_step_core_tb;
  import gse_pkg::*;

  localparam int IDLE_LIMIT   = 20000;  // cycles with no word moving anywhere
  localparam int DRAIN_CYCLES = 2000;   // a body that gives no result is still running

  logic clk;
  logic rst_n;

  gse_in_if  in_ch ();
  gse_out_if out_ch ();
  gse_cfg_if cfg_ch ();

  gravity_sum_euler_step_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // shadow copy of the ship state
  logic [63:0] ship_pos [3];
  logic [63:0] ship_vel [3];
  logic [63:0] thrust_dir [3];
  logic [63:0] thrust_mag;
  logic [63:0] grav_sum [3];
  logic [31:0] step_q16;

  out_word_t expected_states [$];
  int        mismatch_count;
  int        idle_cycles;
  bit        no_idling;   // when set neither side stalls

  initial begin
    clk = 1'b0;
  end
  always #6 clk = ~clk;

  // ---------------------------------------------------------------
  // fixed point helpers
  // ---------------------------------------------------------------

  // signed 64-bit word from sign and magnitude, clamped to the range
  function automatic logic [63:0] clamp_signed(input logic neg, input logic [127:0] m);
    if (!neg) begin
      return (m > 128'h7FFF_FFFF_FFFF_FFFF) ? 64'h7FFF_FFFF_FFFF_FFFF : m[63:0];
    end
    return (m > 128'h8000_0000_0000_0000) ? 64'h8000_0000_0000_0000 : (64'd0 - m[63:0]);
  endfunction

  function automatic logic [63:0] add_clamped(input logic [63:0] a, input logic [63:0] b);
    logic signed [64:0] s;
    s = $signed({a[63], a}) + $signed({b[63], b});
    if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'h7FFF_FFFF_FFFF_FFFF;
    if (s < -65'sh0_8000_0000_0000_0000) return 64'h8000_0000_0000_0000;
    return s[63:0];
  endfunction

  // trunc(a * b / 2^sh) with a signed, b unsigned
  function automatic logic [63:0] scale_by(input logic [63:0] a, input logic [63:0] b,
                                           input int sh);
    logic [63:0]  mag;
    logic [127:0] p;
    mag = a[63] ? (64'd0 - a) : a;
    p = ({64'd0, mag} * {64'd0, b}) >> sh;
    return clamp_signed(a[63], p);
  endfunction

  function automatic int bit_length(input logic [127:0] x);
    int n;
    n = 0;
    for (int i = 0; i < 128; i++) begin
      if (x[i]) n = i + 1;
    end
    return n;
  endfunction

  function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    r = 64'd0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 64'd0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // pull of one body into the gravity sum
  task automatic add_body_pull(input logic [63:0] body [3], input logic [63:0] gm);
    logic signed [64:0] diff;
    logic [63:0]  mag [3];
    logic         neg [3];
    logic [63:0]  unit [3];
    logic [63:0]  biggest;
    logic [63:0]  sum_sq;
    logic [63:0]  root;
    logic [127:0] y;
    logic [127:0] z;
    int len;
    int e;
    biggest = 64'd0;
    for (int i = 0; i < 3; i++) begin
      diff = $signed({body[i][63], body[i]}) - $signed({ship_pos[i][63], ship_pos[i]});
      neg[i] = diff[64];
      mag[i] = neg[i] ? 64'(-diff) : diff[63:0];
      if (mag[i] > biggest) biggest = mag[i];
    end
    if (biggest == 64'd0) return;  // body sits on the ship
    len = bit_length({64'd0, biggest});
    sum_sq = 64'd0;
    for (int i = 0; i < 3; i++) begin
      unit[i] = (len > 31) ? (mag[i] >> (len - 31)) : (mag[i] << (31 - len));
      sum_sq = sum_sq + unit[i] * unit[i];
    end
    root = floor_sqrt(sum_sq);
    e = 118 - 2 * len;
    for (int i = 0; i < 3; i++) begin
      y = ({64'd0, gm} * {64'd0, unit[i]}) / {64'd0, root};
      if (e >= 0) begin
        if (bit_length(y) + e > 128) z = {64'd1, 64'd0};
        else z = (y << e) / {64'd0, sum_sq};
      end else begin
        z = (y >> (-e)) / {64'd0, sum_sq};
      end
      grav_sum[i] = add_clamped(grav_sum[i], clamp_signed(neg[i], z));
    end
  endtask

  // what the ship state becomes after one accepted word
  task automatic advance_ship(input in_word_t w);
    logic [63:0] c [3];
    logic [63:0] acc;
    out_word_t   res;
    c[0] = w.coord_x;
    c[1] = w.coord_y;
    c[2] = w.coord_z;
    case (cmd_t'(w.command))
      CMD_LOAD_POS: begin
        for (int i = 0; i < 3; i++) ship_pos[i] = c[i];
      end
      CMD_LOAD_VEL: begin
        for (int i = 0; i < 3; i++) ship_vel[i] = c[i];
      end
      CMD_LOAD_THRUST: begin
        for (int i = 0; i < 3; i++) thrust_dir[i] = c[i];
        thrust_mag = w.magnitude;
      end
      default: begin
        if (!w.is_barycenter) add_body_pull(c, w.magnitude);
        if (w.last_body) begin
          // semi-implicit: velocity first, position from the new velocity
          for (int i = 0; i < 3; i++) begin
            acc = add_clamped(scale_by(thrust_dir[i], thrust_mag, 56), grav_sum[i]);
            ship_vel[i] = add_clamped(ship_vel[i], scale_by(acc, {32'd0, step_q16}, 16));
          end
          for (int i = 0; i < 3; i++) begin
            ship_pos[i] = add_clamped(ship_pos[i],
                                      scale_by(ship_vel[i], {32'd0, step_q16}, 16));
            grav_sum[i] = 64'd0;
          end
          res.pos_x = ship_pos[0];
          res.pos_y = ship_pos[1];
          res.pos_z = ship_pos[2];
          res.vel_x = ship_vel[0];
          res.vel_y = ship_vel[1];
          res.vel_z = ship_vel[2];
          expected_states.push_back(res);
        end
      end
    endcase
  endtask

  // ---------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------

  // returns at the edge that took the word; valid stays up for a back-to-back word
  task automatic send_word(input in_word_t w);
    int gap;
    gap = no_idling ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    advance_ship(w);
  endtask

  // let the block settle: all results in, then time for a body still grinding
  task automatic wait_quiet();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_states.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_step(input logic [31:0] v);
    wait_quiet();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    step_q16 = v;
  endtask

  function automatic in_word_t make_word(input cmd_t c, input logic [63:0] x,
                                         input logic [63:0] y, input logic [63:0] z,
                                         input logic [63:0] m, input logic bary,
                                         input logic last);
    in_word_t w;
    w.command       = c;
    w.coord_x       = x;
    w.coord_y       = y;
    w.coord_z       = z;
    w.magnitude     = m;
    w.is_barycenter = bary;
    w.last_body     = last;
    return w;
  endfunction

  // mix of full-range, moderate and extreme coordinates
  function automatic logic [63:0] rand_coord();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0:       return r;
      1:       return 64'h7FFF_FFFF_FFFF_FFFF;
      2:       return 64'h8000_0000_0000_0000;
      3:       return {{32{r[31]}}, r[31:0]};
      4:       return {{24{r[39]}}, r[39:0]};
      default: return {{14{r[49]}}, r[49:0]};
    endcase
  endfunction

  function automatic logic [63:0] rand_magnitude();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0:       return r;
      1:       return 64'hFFFF_FFFF_FFFF_FFFF;
      2:       return 64'd0;
      3:       return {24'd0, r[39:0]};
      default: return {16'd0, r[47:0]};
    endcase
  endfunction

  // ---------------------------------------------------------------
  // result checking and sink stalls
  // ---------------------------------------------------------------

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t %s expected %h actual %h", $time, name, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  int sink_hold;

  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      sink_hold = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_states.size() == 0) begin
          $display("%0t unexpected result expected none actual %h", $time, out_ch.data);
          mismatch_count++;
        end else begin
          want = expected_states.pop_front();
          check_field("pos_x", want.pos_x, out_ch.data.pos_x);
          check_field("pos_y", want.pos_y, out_ch.data.pos_y);
          check_field("pos_z", want.pos_z, out_ch.data.pos_z);
          check_field("vel_x", want.vel_x, out_ch.data.vel_x);
          check_field("vel_y", want.vel_y, out_ch.data.vel_y);
          check_field("vel_z", want.vel_z, out_ch.data.vel_z);
        end
        sink_hold = no_idling ? 0 : $urandom_range(0, 15);
      end else if (sink_hold > 0) begin
        sink_hold--;
      end
      out_ch.ready <= (sink_hold == 0);
    end
  end

  // watchdog: any moving word resets the count
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("gravity_sum_euler_step_core_tb: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------

  // loads with flags set must not emit anything; extremes of every field
  task automatic test_loads_and_flags();
    send_word(make_word(CMD_LOAD_POS, 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
                        64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1));
    send_word(make_word(CMD_LOAD_VEL, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
                        64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 1'b0, 1'b1));
    send_word(make_word(CMD_LOAD_THRUST, 64'h7FFF_FFFF_FFFF_FFFF,
                        64'h8000_0000_0000_0000, 64'h0000_0100_0000_0000,
                        64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0));
    // saturating step with everything at the rails
    send_word(make_word(CMD_BODY, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
                        64'h7FFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1));
  endtask

  task automatic test_special_bodies();
    // sane ship near origin, one earth-like body
    send_word(make_word(CMD_LOAD_POS, 64'h0000_0100_0000_0000, 64'd0, 64'd0,
                        64'd0, 1'b0, 1'b0));
    send_word(make_word(CMD_LOAD_VEL, 64'd0, 64'h0000_0000_1000_0000, 64'd0,
                        64'd0, 1'b0, 1'b0));
    send_word(make_word(CMD_LOAD_THRUST, 64'h0000_0100_0000_0000, 64'd0, 64'd0,
                        64'h0000_0000_0100_0000, 1'b0, 1'b0));
    send_word(make_word(CMD_BODY, 64'd0, 64'd0, 64'd0, 64'h0000_0040_0000_0000,
                        1'b0, 1'b0));
    // barycenter in the middle, then one that is also last
    send_word(make_word(CMD_BODY, 64'd5, 64'd7, 64'd9, 64'hFFFF_FFFF_FFFF_FFFF,
                        1'b1, 1'b0));
    send_word(make_word(CMD_BODY, 64'd1, 64'd2, 64'd3, 64'h0000_0040_0000_0000,
                        1'b1, 1'b1));
    // body right on the ship adds nothing
    send_word(make_word(CMD_BODY, ship_pos[0], ship_pos[1], ship_pos[2],
                        64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1));
    // tiny separation: the huge up-scale path saturates the pull
    send_word(make_word(CMD_BODY, ship_pos[0] + 64'd1, ship_pos[1], ship_pos[2] - 64'd1,
                        64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0));
    send_word(make_word(CMD_BODY, ship_pos[0] - 64'd3, ship_pos[1] + 64'd2, ship_pos[2],
                        64'd1, 1'b0, 1'b1));
    // widest separation, smallest and largest mass
    send_word(make_word(CMD_BODY, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
                        64'h8000_0000_0000_0000, 64'd1, 1'b0, 1'b0));
    send_word(make_word(CMD_BODY, 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
                        64'h7FFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1));
  endtask

  // zero step leaves the ship where it is
  task automatic test_zero_step();
    write_step(32'd0);
    send_word(make_word(CMD_BODY, 64'h0000_0200_0000_0000, 64'd0, 64'd0,
                        64'h0000_1000_0000_0000, 1'b0, 1'b1));
  endtask

  // mostly whole flights with random content, some loose words
  task automatic test_random_flights(input int n_words);
    int sent;
    int bodies;
    cmd_t c;
    sent = 0;
    while (sent < n_words) begin
      if ($urandom_range(0, 9) < 8) begin
        if ($urandom_range(0, 3) != 0) begin
          send_word(make_word(CMD_LOAD_POS, rand_coord(), rand_coord(), rand_coord(),
                              rand_magnitude(), 1'($urandom), 1'($urandom)));
          sent++;
        end
        if ($urandom_range(0, 2) != 0) begin
          send_word(make_word(CMD_LOAD_VEL, rand_coord(), rand_coord(), rand_coord(),
                              rand_magnitude(), 1'($urandom), 1'($urandom)));
          sent++;
        end
        if ($urandom_range(0, 2) != 0) begin
          send_word(make_word(CMD_LOAD_THRUST, rand_coord(), rand_coord(), rand_coord(),
                              rand_magnitude(), 1'($urandom), 1'($urandom)));
          sent++;
        end
        bodies = $urandom_range(1, 2);
        for (int b = 0; b < bodies; b++) begin
          if ($urandom_range(0, 19) == 0) begin
            send_word(make_word(CMD_BODY, ship_pos[0], ship_pos[1], ship_pos[2],
                                rand_magnitude(), 1'b0, b == bodies - 1));
          end else begin
            send_word(make_word(CMD_BODY, rand_coord(), rand_coord(), rand_coord(),
                                rand_magnitude(), $urandom_range(0, 4) == 0,
                                b == bodies - 1));
          end
          sent++;
        end
      end else begin
        c = cmd_t'($urandom_range(0, 3));
        send_word(make_word(c, rand_coord(), rand_coord(), rand_coord(),
                            rand_magnitude(), 1'($urandom), 1'($urandom)));
        sent++;
      end
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.data     = '0;
    out_ch.ready   = 1'b0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.data    = '0;
    mismatch_count = 0;
    idle_cycles    = 0;
    no_idling      = 1'b0;
    step_q16       = STEP_RESET;
    thrust_mag     = 64'd0;
    for (int i = 0; i < 3; i++) begin
      ship_pos[i]   = 64'd0;
      ship_vel[i]   = 64'd0;
      thrust_dir[i] = 64'd0;
      grav_sum[i]   = 64'd0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_loads_and_flags();
    test_special_bodies();
    test_zero_step();

    // phases through the step range, one with no stalls at all
    write_step(32'h0001_0000);
    test_random_flights(380);
    write_step(32'hFFFF_FFFF);
    test_random_flights(380);
    write_step(32'd1);
    no_idling = 1'b1;
    test_random_flights(380);
    no_idling = 1'b0;
    write_step($urandom_range(1, 32'h0010_0000));
    test_random_flights(380);
    write_step($urandom);
    test_random_flights(380);

    wait_quiet();
    if (mismatch_count == 0 && expected_states.size() == 0) begin
      $display("gravity_sum_euler_step_core_tb: clean");
    end else begin
      $display("gravity_sum_euler_step_core_tb: errors");
    end
    $finish;
  end

endmodule
`default_nettype wire
